[rtl/ppmfg_pkg.sv]
// Shared types and constants for the PPM frame generator.
`timescale 1ns / 1ps

package ppmfg_pkg;

    localparam int PULSE_W  = 10;
    localparam int FRAME_W  = 16;
    localparam int CHW_W    = 12;
    localparam int CHAN_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PULSE_W-1:0] RST_PULSE_WIDTH  = 10'd300;
    localparam logic [FRAME_W-1:0] RST_FRAME_PERIOD = 16'd22500;
    localparam logic [CHW_W-1:0]   RST_CHAN_WIDTH   = 12'd1500;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd2;

    typedef struct packed {
        logic              command;
        logic [CHAN_W-1:0] channel;
        logic [CHW_W-1:0]  width;
    } t_in_item;

    typedef struct packed {
        logic              pin_level;
        logic [SLOT_W-1:0] slot;
        logic              frame_start;
    } t_out_item;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic [FRAME_W-1:0] frame_period;
        logic               active_level;
    } t_cfg;

endpackage

[rtl/ppmfg_slot_engine.sv]
// Slot sequencer: phase timer, slot counter, frame accounting and channel width store.
`timescale 1ns / 1ps

module ppmfg_slot_engine #(
    parameter int CHANNELS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  ppmfg_pkg::t_in_item  i_item,
    input  ppmfg_pkg::t_cfg      i_cfg,
    output ppmfg_pkg::t_out_item o_result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [ppmfg_pkg::SLOT_W-1:0] LAST_SLOT = ppmfg_pkg::SLOT_W'(CHANNELS);

    logic                                r_phase;
    logic                                r_first;
    logic [ppmfg_pkg::SLOT_W-1:0]        r_slot;
    logic [ppmfg_pkg::FRAME_W-1:0]       r_timer;
    logic [ppmfg_pkg::FRAME_W-1:0]       r_used;
    logic [ppmfg_pkg::CHW_W-1:0]         r_width [CHANNELS];

    logic                                n_phase;
    logic                                n_first;
    logic [ppmfg_pkg::SLOT_W-1:0]        n_slot;
    logic [ppmfg_pkg::FRAME_W-1:0]       n_timer;
    logic [ppmfg_pkg::FRAME_W-1:0]       n_used;

    logic                                start;
    logic                                in_sync;
    logic                                wr_hit;
    logic [ppmfg_pkg::CHW_W-1:0]         rd_width;
    logic [ppmfg_pkg::FRAME_W:0]         sync_sum;

    assign in_sync  = (r_slot >= LAST_SLOT);
    assign wr_hit   = i_accept && (i_item.command == ppmfg_pkg::CMD_WRITE)
                      && ({1'b0, i_item.channel} < LAST_SLOT);
    assign rd_width = in_sync ? ppmfg_pkg::RST_CHAN_WIDTH : r_width[r_slot[IDX_W-1:0]];
    assign sync_sum = {1'b0, r_used} + {7'b0, i_cfg.pulse_width};

    always_comb begin
        n_phase = r_phase;
        n_first = r_first;
        n_slot  = r_slot;
        n_timer = r_timer;
        n_used  = r_used;
        start   = 1'b0;
        if (i_accept && (i_item.command == ppmfg_pkg::CMD_TICK)) begin
            if (r_timer > 16'd1) begin
                n_timer = r_timer - 16'd1;
            end else if (r_phase) begin
                // pulse begins
                n_slot  = (r_first || in_sync) ? '0 : r_slot + 4'd1;
                n_first = 1'b0;
                start   = (n_slot == '0);
                n_phase = 1'b0;
                n_timer = (i_cfg.pulse_width != '0) ? {6'b0, i_cfg.pulse_width} : 16'd1;
            end else begin
                // pulse ends
                n_phase = 1'b1;
                if (in_sync) begin
                    n_timer = (sync_sum < {1'b0, i_cfg.frame_period})
                              ? 16'({1'b0, i_cfg.frame_period} - sync_sum) : 16'd1;
                    n_used  = '0;
                end else begin
                    n_timer = (rd_width > {2'b0, i_cfg.pulse_width})
                              ? {4'b0, rd_width - {2'b0, i_cfg.pulse_width}} : 16'd1;
                    n_used  = r_used + {4'b0, rd_width};
                end
            end
        end
    end

    always_comb begin
        o_result.pin_level   = n_phase ? ~i_cfg.active_level : i_cfg.active_level;
        o_result.slot        = n_slot;
        o_result.frame_start = start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b1;
            r_first <= 1'b1;
            r_slot  <= '0;
            r_timer <= 16'd1;
            r_used  <= '0;
        end else begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_slot  <= n_slot;
            r_timer <= n_timer;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_width[i] <= ppmfg_pkg::RST_CHAN_WIDTH;
            end
        end else if (wr_hit) begin
            r_width[i_item.channel[IDX_W-1:0]] <= i_item.width;
        end
    end

endmodule

[rtl/ppm_frame_generator_core.sv]
// Top level of the PPM frame generator: config registers, handshake and result register.
//
//  channel   direction  signals                             payload
//  input     in         i_in_valid / o_in_ready             i_in_item  (t_in_item)
//  result    out        o_out_valid / i_out_ready           o_out_item (t_out_item)
//  config    in         i_cfg_we / i_cfg_index / i_cfg_data  write only
//
// One transfer in per cycle while o_in_ready is high; its result is registered in r_out.
// The state update and result are one pass of the slot sequencer's countdown and compare.
// Input is taken whenever the result register is empty or is being read this cycle.
// Synchronous active-low reset restores config defaults and all channel widths to 1500.
`timescale 1ns / 1ps

module ppm_frame_generator_core #(
    parameter int CHANNELS = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  ppmfg_pkg::t_in_item                   i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output ppmfg_pkg::t_out_item                  o_out_item,
    input  logic                                  i_cfg_we,
    input  logic [ppmfg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppmfg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    ppmfg_pkg::t_cfg      r_cfg;
    ppmfg_pkg::t_out_item r_out;
    logic                 r_out_valid;
    ppmfg_pkg::t_out_item result;
    logic                 accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_width  <= ppmfg_pkg::RST_PULSE_WIDTH;
            r_cfg.frame_period <= ppmfg_pkg::RST_FRAME_PERIOD;
            r_cfg.active_level <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppmfg_pkg::REG_PULSE_WIDTH:  r_cfg.pulse_width  <= i_cfg_data[9:0];
                ppmfg_pkg::REG_FRAME_PERIOD: r_cfg.frame_period <= i_cfg_data;
                ppmfg_pkg::REG_ACTIVE_LEVEL: r_cfg.active_level <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ppmfg_slot_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

endmodule
